// ===== sv/tensor_dim_reorder_address_gen_defines.svh =====
// -----------------------------------------------------------------------------
// tensor_dim_reorder_address_gen_defines
// Assertion macros used by the checker file of the address generator.
// -----------------------------------------------------------------------------
`ifndef TENSOR_DIM_REORDER_ADDRESS_GEN_DEFINES_SVH
`define TENSOR_DIM_REORDER_ADDRESS_GEN_DEFINES_SVH

// clocked on clock, ignored while reset is high
`define TRDG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked on clock, checked during reset as well
`define TRDG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/trdg_pkg.sv =====
// -----------------------------------------------------------------------------
// trdg_pkg
// Widths, register codes, command/status types and helpers of the reorder
// address generator.
// -----------------------------------------------------------------------------
package trdg_pkg;

   localparam int MAX_DIMS      = 4;
   localparam int NUM_SIZE_REGS = 4;
   localparam int EXT_W         = 11;
   localparam int CNT_W         = 10;
   localparam int ADDR_W        = 40;
   localparam int MAX_EXTENT    = 1024;
   localparam int NDREG_W       = 3;
   localparam int MASK_W        = 4;
   localparam int DIM_IDX_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NDIM_W        = $clog2(MAX_DIMS + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_DIMS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REDUCED_MASK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM0    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM2    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM3    = 3'd5;

   typedef struct packed {
      logic accept;    // latch the request word
      logic advance;   // step or rewind the odometer
      logic mac;       // one address accumulation step
      logic load;      // move the finished word into the output register
   } cmd_type;

   typedef struct packed {
      logic mac_last;  // current accumulation step covers the last dimension
   } sts_type;

   function automatic logic [EXT_W-1:0] clamp_extent(input logic [CSR_DATA_W-1:0] s);
      logic [EXT_W-1:0] r;
      if (s == '0) begin
         r = EXT_W'(1);
      end else if (int'(s) > MAX_EXTENT) begin
         r = EXT_W'(MAX_EXTENT);
      end else begin
         r = EXT_W'(s);
      end
      return r;
   endfunction

endpackage

// ===== sv/trdg_req_if.sv =====
// -----------------------------------------------------------------------------
// trdg_req_if
// Request channel: valid/ready handshake carrying the restart flag.
// -----------------------------------------------------------------------------
interface trdg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// ===== sv/trdg_rsp_if.sv =====
// -----------------------------------------------------------------------------
// trdg_rsp_if
// Result channel: valid/ready handshake carrying source address, destination
// index and the final-element flag.
// -----------------------------------------------------------------------------
interface trdg_rsp_if import trdg_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] src_addr;
   logic [ADDR_W-1:0] dst_index;
   logic              last;

   modport source (output valid, output src_addr, output dst_index, output last,
                   input ready);
   modport sink   (input valid, input src_addr, input dst_index, input last,
                   output ready);
endinterface

// ===== sv/trdg_ctrl.sv =====
// -----------------------------------------------------------------------------
// trdg_ctrl
// Sequencer: accept, odometer step, one accumulation per dimension, then hand
// the word to the output register.
// -----------------------------------------------------------------------------
module trdg_ctrl import trdg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADV  = 2'd1;
   localparam logic [1:0] ST_MAC  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in    = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac = 1'b1;
            if (sts.mac_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // output register free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/trdg_dp.sv =====
// -----------------------------------------------------------------------------
// trdg_dp
// Datapath: configuration registers, per-dimension odometer, element counter,
// row-major address accumulator and the output word register.
// -----------------------------------------------------------------------------
module trdg_dp import trdg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_restart,
   output logic [ADDR_W-1:0]     rsp_src_addr,
   output logic [ADDR_W-1:0]     rsp_dst_index,
   output logic                  rsp_last,
   input  cmd_type               cmd,
   output sts_type               sts
);

   logic [NDREG_W-1:0]    num_dims_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic [CSR_DATA_W-1:0] size_ff [NUM_SIZE_REGS];
   logic                  started_ff;
   logic                  restart_ff;

   logic [CNT_W-1:0]      cnt_ff [MAX_DIMS];
   logic [CNT_W-1:0]      cnt_in [MAX_DIMS];
   logic [ADDR_W-1:0]     out_count_ff, out_count_in;
   logic [DIM_IDX_W-1:0]  k_ff;
   logic [ADDR_W-1:0]     acc_ff, acc_in;

   logic [ADDR_W-1:0]     src_addr_ff, dst_index_ff;
   logic                  last_ff;

   logic [NDIM_W-1:0]     n_act;
   logic [EXT_W-1:0]      ext [MAX_DIMS];
   logic [MAX_DIMS-1:0]   active, red, at_max, inner_max;
   logic                  all_max, rewind, csr_hit;
   logic [ADDR_W+EXT_W-1:0] prod;

   // ---- configuration view ------------------------------------------------
   always_comb begin
      if (num_dims_ff == '0) begin
         n_act = NDIM_W'(1);
      end else if (int'(num_dims_ff) > MAX_DIMS) begin
         n_act = NDIM_W'(MAX_DIMS);
      end else begin
         n_act = NDIM_W'(num_dims_ff);
      end
   end

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
      if (d < NUM_SIZE_REGS) begin : g_sized
         assign ext[d] = clamp_extent(size_ff[d]);
         assign red[d] = mask_ff[d];
      end else begin : g_unsized
         assign ext[d] = EXT_W'(1);
         assign red[d] = 1'b0;
      end
      assign active[d] = (d < int'(n_act));
      assign at_max[d] = ((EXT_W'(cnt_ff[d]) + EXT_W'(1)) >= ext[d]);
   end

   // dim e sits inside dim d when both share the reduced flag and e is higher,
   // or when d is reduced and e is not
   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         inner_max[d] = 1'b1;
         for (int e = 0; e < MAX_DIMS; e++) begin
            if (active[e] && ((red[e] == red[d]) ? (e > d) : (red[d] && !red[e]))) begin
               inner_max[d] = inner_max[d] & at_max[e];
            end
         end
      end
   end

   assign all_max = &(at_max | ~active);
   assign rewind  = restart_ff || !started_ff;

   // ---- odometer and element counter ---------------------------------------
   always_comb begin
      out_count_in = out_count_ff;
      for (int d = 0; d < MAX_DIMS; d++) begin
         cnt_in[d] = cnt_ff[d];
      end
      if (cmd.advance) begin
         if (rewind) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
               cnt_in[d] = '0;
            end
            out_count_in = '0;
         end else begin
            for (int d = 0; d < MAX_DIMS; d++) begin
               if (active[d] && inner_max[d]) begin
                  cnt_in[d] = at_max[d] ? '0 : cnt_ff[d] + 1'b1;
               end
            end
            out_count_in = all_max ? '0 : out_count_ff + 1'b1;
         end
      end
   end

   // ---- address accumulation, one dimension per cycle ----------------------
   assign prod   = acc_ff * ext[k_ff];
   assign acc_in = prod[ADDR_W-1:0] + ADDR_W'(cnt_ff[k_ff]);

   assign sts.mac_last = ((int'(k_ff) + 1) == int'(n_act));
   assign csr_hit      = (csr_index <= REG_SIZE_DIM3);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= NDREG_W'(4);
         mask_ff     <= '0;
         for (int i = 0; i < NUM_SIZE_REGS; i++) begin
            size_ff[i] <= CSR_DATA_W'(1);
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NUM_DIMS:     num_dims_ff <= csr_wdata[NDREG_W-1:0];
            REG_REDUCED_MASK: mask_ff     <= csr_wdata[MASK_W-1:0];
            REG_SIZE_DIM0:    size_ff[0]  <= csr_wdata;
            REG_SIZE_DIM1:    size_ff[1]  <= csr_wdata;
            REG_SIZE_DIM2:    size_ff[2]  <= csr_wdata;
            REG_SIZE_DIM3:    size_ff[3]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         out_count_ff <= '0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            cnt_ff[d] <= '0;
         end
      end else begin
         if (csr_we && csr_hit) begin
            started_ff <= 1'b0;
         end else if (cmd.advance) begin
            started_ff <= 1'b1;
         end
         out_count_ff <= out_count_in;
         for (int d = 0; d < MAX_DIMS; d++) begin
            cnt_ff[d] <= cnt_in[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         restart_ff <= req_restart;
      end
      if (cmd.advance) begin
         acc_ff <= '0;
         k_ff   <= '0;
      end else if (cmd.mac) begin
         acc_ff <= acc_in;
         k_ff   <= k_ff + 1'b1;
      end
      if (cmd.load) begin
         src_addr_ff  <= acc_ff;
         dst_index_ff <= out_count_ff;
         last_ff      <= all_max;
      end
   end

   assign rsp_src_addr  = src_addr_ff;
   assign rsp_dst_index = dst_index_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== sv/tensor_dim_reorder_address_gen.sv =====
// Sequence: request accept, odometer step, one multiply-add per active dimension,
//   then the word moves into the output register once that is free or draining.
//   A new request is taken only after the previous word has been loaded.
// The output register holds a result while the next request is accepted.
// Reset (synchronous): registers to defaults, odometer cleared, no result
//   pending; the first request after reset or a register write rewinds.
// -----------------------------------------------------------------------------
// tensor_dim_reorder_address_gen
// Address generator for regrouped tensor traversal, reduced dims outermost.
// -----------------------------------------------------------------------------
module tensor_dim_reorder_address_gen import trdg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   trdg_req_if.sink              req_chan,
   trdg_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   trdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   trdg_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_restart   (req_chan.restart),
      .rsp_src_addr  (rsp_chan.src_addr),
      .rsp_dst_index (rsp_chan.dst_index),
      .rsp_last      (rsp_chan.last),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule

// ===== sv/trdg_checker.sv =====
// -----------------------------------------------------------------------------
// trdg_checker
// Port-level checks of the address generator, bound to the top level.
// -----------------------------------------------------------------------------
`include "tensor_dim_reorder_address_gen_defines.svh"

module trdg_checker import trdg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_src_addr,
   input logic [ADDR_W-1:0] rsp_dst_index,
   input logic              rsp_last
);

   // stalled result word holds
   `TRDG_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_addr) && $stable(rsp_dst_index) && $stable(rsp_last), "result word changed under stall")

   // reset leaves no result pending
   `TRDG_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // one word in flight: request side closes right after an accept
   `TRDG_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request accepted while busy")

   // a result never appears in the cycle after an accept
   `TRDG_ASSERT(a_min_latency, req_valid && req_ready && !rsp_valid |=> !rsp_valid, "result too early")

endmodule

bind tensor_dim_reorder_address_gen trdg_checker u_trdg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_src_addr  (rsp_chan.src_addr),
   .rsp_dst_index (rsp_chan.dst_index),
   .rsp_last      (rsp_chan.last)
);
